/* rtl/tlsf_pkg.sv */
// ----------------------------------------------------------------------------
// tlsf_pkg
// Shared types, constants and class mapping for the segregated-fit allocator.
// ----------------------------------------------------------------------------
package tlsf_pkg;

  localparam int ADDR_W    = 16;
  localparam int LEN_W     = 17;
  localparam int FL_COUNT  = 17;
  localparam int SL_BITS   = 4;
  localparam int SL_COUNT  = 16;
  localparam int CLS_W     = 9;
  localparam int CLS_COUNT = FL_COUNT * SL_COUNT;
  localparam int REC_DEPTH = 65536;

  localparam logic [LEN_W-1:0]  NO_LINK   = 17'h10000;
  localparam logic [LEN_W-1:0]  POOL_LEN  = 17'h10000;
  localparam logic [LEN_W-1:0]  HDR_LEN   = 17'd16;
  localparam logic [LEN_W-1:0]  MIN_LEN   = 17'd32;
  localparam logic [ADDR_W-1:0] HDR_OFS   = 16'd16;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             free;
    logic [LEN_W-1:0] pprev;
    logic [LEN_W-1:0] pnext;
    logic [LEN_W-1:0] fprev;
    logic [LEN_W-1:0] fnext;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    rec_t              wr_data;
  } rec_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [CLS_W-1:0] rd_addr;
    logic             wr_en;
    logic [CLS_W-1:0] wr_addr;
    logic [LEN_W-1:0] wr_data;
  } head_req_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_NO_SPACE = 2'd1,
    STAT_IGNORED  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE,
    ST_A_MAP, ST_A_FIND, ST_A_HEAD, ST_A_CHK, ST_A_CHK2, ST_A_CLR, ST_A_CLRW,
    ST_RM_RD, ST_RM_GET, ST_RM_PW, ST_RM_N, ST_RM_NW,
    ST_SP_NB_RD, ST_SP_NB_WR, ST_SP_NX, ST_SP_NXW, ST_SP_B, ST_SP_BW,
    ST_IN_RD, ST_IN_GET, ST_IN_HEAD, ST_IN_HRD, ST_IN_HW, ST_IN_FIN,
    ST_F_MK, ST_F_MKW,
    ST_M_RD, ST_M_NX, ST_M_NXF, ST_M_N1, ST_M_N2, ST_M_N3, ST_M_N4, ST_M_N5,
    ST_M_PV, ST_M_PV2, ST_M_PVF, ST_M_P1, ST_M_P2, ST_M_P3, ST_M_P4, ST_M_P5,
    ST_LF, ST_LF_H, ST_LF_L, ST_OUT
  } state_t;

  function automatic logic [4:0] top_bit17(input logic [16:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] top_bit16(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [4:0] low_bit17(input logic [16:0] v);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 16; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] low_bit16(input logic [15:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  // class index is {fl, sl}
  function automatic logic [CLS_W-1:0] class_of(input logic [LEN_W-1:0] len);
    logic [4:0]       f;
    logic [LEN_W-1:0] d;
    logic [LEN_W-1:0] sh;
    logic [3:0]       s;
    f  = top_bit17(len);
    d  = len - (17'd1 << f);
    sh = d >> (f - 5'(SL_BITS));
    if (len == '0) begin
      s = 4'd0;
    end else if (f < 5'(SL_BITS)) begin
      s = d[3:0];
    end else begin
      s = sh[3:0];
    end
    return {f, s};
  endfunction

  localparam logic [CLS_W-1:0] POOL_CLASS = class_of(POOL_LEN);

endpackage

/* rtl/tlsf_ram.sv */
// ----------------------------------------------------------------------------
// tlsf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tlsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tlsf_ctrl.sv */
// ----------------------------------------------------------------------------
// tlsf_ctrl
// Sequencer that walks block headers and class lists, and holds the bitmaps.
// ----------------------------------------------------------------------------
module tlsf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_operation,
  input  logic [15:0]                 in_request_bytes,
  input  logic [15:0]                 in_block_address,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic [15:0]                 out_result_address,
  output logic [16:0]                 out_largest_free_bytes,
  output tlsf_pkg::rec_req_t          rec_req,
  input  tlsf_pkg::rec_t              rec_q,
  output tlsf_pkg::head_req_t         head_req,
  input  logic [tlsf_pkg::LEN_W-1:0]  head_raw
);
  import tlsf_pkg::*;

  state_t             state_r, state_nxt, ret_r, ret_nxt;
  logic [ADDR_W-1:0]  b_r, b_nxt, x_r, x_nxt, m_r, m_nxt, addr_r, addr_nxt;
  logic [LEN_W-1:0]   p_r, p_nxt, n_r, n_nxt, len_r, len_nxt, lk_r, lk_nxt;
  logic [LEN_W-1:0]   total_r, total_nxt, lf_r, lf_nxt;
  logic [CLS_W-1:0]   cls_r, cls_nxt;
  logic [CLS_W-1:0]   init_r, init_nxt;
  rec_t               rec_r, rec_nxt;
  logic               head_vld_r, head_vld_nxt;
  logic [SL_COUNT-1:0] sl_bm_r [FL_COUNT];
  logic [SL_COUNT-1:0] sl_bm_nxt [FL_COUNT];
  status_t            status_r, status_nxt;

  logic [FL_COUNT-1:0] fl_bm;
  logic [LEN_W-1:0]    head_q;
  logic [4:0]          tb;
  logic [LEN_W-1:0]    rounded;
  logic [15:0]         m_sl;
  logic [FL_COUNT-1:0] m_fl;
  logic [4:0]          ff;
  logic                found;
  logic [CLS_W-1:0]    found_cls;
  logic [4:0]          tf;
  logic [3:0]          ts;
  logic [CLS_W-1:0]    q_cls;
  logic [CLS_W-1:0]    total_req;
  logic [17:0]         split_lim;
  logic                do_split;
  logic                q_bit;
  logic                rm_empty;

  always_comb begin
    for (int i = 0; i < FL_COUNT; i++) begin
      fl_bm[i] = |sl_bm_r[i];
    end
  end

  assign head_q = head_vld_r ? head_raw : NO_LINK;

  // allocation size rounded up to the next class boundary
  assign tb        = top_bit17(total_r);
  assign rounded   = (total_r >= 17'(SL_COUNT)) ?
                     total_r + ((17'd1 << (tb - 5'(SL_BITS))) - 17'd1) : total_r;
  assign total_req = class_of(rounded);

  assign m_sl      = sl_bm_r[cls_r[8:4]] & (16'hFFFF << cls_r[3:0]);
  assign m_fl      = fl_bm & ({FL_COUNT{1'b1}} << (6'(cls_r[8:4]) + 6'd1));
  assign ff        = low_bit17(m_fl);
  assign found     = (m_sl != '0) || (m_fl != '0);
  assign found_cls = (m_sl != '0) ? {cls_r[8:4], low_bit16(m_sl)}
                                  : {ff, low_bit16(sl_bm_r[ff])};

  assign tf        = top_bit17(fl_bm);
  assign ts        = top_bit16(sl_bm_r[tf]);

  assign q_cls     = class_of(rec_q.len);
  assign q_bit     = sl_bm_r[q_cls[8:4]][q_cls[3:0]];
  assign rm_empty  = rec_q.fprev[16] ? rec_q.fnext[16] : !q_bit;
  assign split_lim = {1'b0, total_r} + {1'b0, MIN_LEN};
  assign do_split  = {1'b0, rec_q.len} >= split_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ret_r   <= ST_LF;
      init_r  <= '0;
      for (int i = 0; i < FL_COUNT; i++) begin
        sl_bm_r[i] <= (5'(i) == POOL_CLASS[8:4]) ? (16'd1 << POOL_CLASS[3:0]) : '0;
      end
      head_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      init_r     <= init_nxt;
      sl_bm_r    <= sl_bm_nxt;
      head_vld_r <= head_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r      <= b_nxt;
    x_r      <= x_nxt;
    m_r      <= m_nxt;
    addr_r   <= addr_nxt;
    p_r      <= p_nxt;
    n_r      <= n_nxt;
    len_r    <= len_nxt;
    lk_r     <= lk_nxt;
    total_r  <= total_nxt;
    lf_r     <= lf_nxt;
    cls_r    <= cls_nxt;
    rec_r    <= rec_nxt;
    status_r <= status_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:     state_nxt = (init_r == CLS_W'(CLS_COUNT - 1)) ? ST_IDLE : ST_INIT;
      ST_IDLE: begin
        if (start) begin
          if (!in_operation) state_nxt = ST_A_MAP;
          else if (in_block_address == '0) state_nxt = ST_LF;
          else state_nxt = ST_F_MK;
        end
      end
      ST_A_MAP:    state_nxt = ST_A_FIND;
      ST_A_FIND:   state_nxt = found ? ST_A_HEAD : ST_LF;
      ST_A_HEAD:   state_nxt = head_q[16] ? ST_LF : ST_RM_RD;
      ST_RM_RD:    state_nxt = ST_RM_GET;
      ST_RM_GET:   state_nxt = rec_q.fprev[16] ? ST_RM_N : ST_RM_PW;
      ST_RM_PW:    state_nxt = ST_RM_N;
      ST_RM_N:     state_nxt = n_r[16] ? ret_r : ST_RM_NW;
      ST_RM_NW:    state_nxt = ret_r;
      ST_A_CHK:    state_nxt = ST_A_CHK2;
      ST_A_CHK2:   state_nxt = do_split ? ST_SP_NB_RD : ST_A_CLR;
      ST_SP_NB_RD: state_nxt = ST_SP_NB_WR;
      ST_SP_NB_WR: state_nxt = ST_SP_NX;
      ST_SP_NX:    state_nxt = lk_r[16] ? ST_SP_B : ST_SP_NXW;
      ST_SP_NXW:   state_nxt = ST_SP_B;
      ST_SP_B:     state_nxt = ST_SP_BW;
      ST_SP_BW:    state_nxt = ST_IN_RD;
      ST_A_CLR:    state_nxt = ST_A_CLRW;
      ST_A_CLRW:   state_nxt = ST_LF;
      ST_IN_RD:    state_nxt = ST_IN_GET;
      ST_IN_GET:   state_nxt = ST_IN_HEAD;
      ST_IN_HEAD:  state_nxt = head_q[16] ? ST_IN_FIN : ST_IN_HRD;
      ST_IN_HRD:   state_nxt = ST_IN_HW;
      ST_IN_HW:    state_nxt = ST_IN_FIN;
      ST_IN_FIN:   state_nxt = ret_r;
      ST_F_MK:     state_nxt = ST_F_MKW;
      ST_F_MKW:    state_nxt = ST_M_RD;
      ST_M_RD:     state_nxt = ST_M_NX;
      ST_M_NX:     state_nxt = rec_q.pnext[16] ? ST_M_PV : ST_M_NXF;
      ST_M_NXF:    state_nxt = rec_q.free ? ST_RM_RD : ST_M_PV;
      ST_M_N1:     state_nxt = ST_M_N2;
      ST_M_N2:     state_nxt = ST_M_N3;
      ST_M_N3:     state_nxt = ST_M_N4;
      ST_M_N4:     state_nxt = lk_r[16] ? ST_M_PV : ST_M_N5;
      ST_M_N5:     state_nxt = ST_M_PV;
      ST_M_PV:     state_nxt = ST_M_PV2;
      ST_M_PV2:    state_nxt = rec_q.pprev[16] ? ST_IN_RD : ST_M_PVF;
      ST_M_PVF:    state_nxt = rec_q.free ? ST_RM_RD : ST_IN_RD;
      ST_M_P1:     state_nxt = ST_M_P2;
      ST_M_P2:     state_nxt = ST_M_P3;
      ST_M_P3:     state_nxt = ST_M_P4;
      ST_M_P4:     state_nxt = lk_r[16] ? ST_IN_RD : ST_M_P5;
      ST_M_P5:     state_nxt = ST_IN_RD;
      ST_LF:       state_nxt = (fl_bm != '0) ? ST_LF_H : ST_OUT;
      ST_LF_H:     state_nxt = head_q[16] ? ST_OUT : ST_LF_L;
      ST_LF_L:     state_nxt = ST_OUT;
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    rec_t w;
    ret_nxt      = ret_r;
    b_nxt        = b_r;
    x_nxt        = x_r;
    m_nxt        = m_r;
    addr_nxt     = addr_r;
    p_nxt        = p_r;
    n_nxt        = n_r;
    len_nxt      = len_r;
    lk_nxt       = lk_r;
    total_nxt    = total_r;
    lf_nxt       = lf_r;
    cls_nxt      = cls_r;
    init_nxt     = init_r;
    rec_nxt      = rec_r;
    status_nxt   = status_r;
    head_vld_nxt = head_vld_r;
    sl_bm_nxt    = sl_bm_r;
    rec_req      = '0;
    head_req     = '0;
    w            = rec_q;
    case (state_r)
      ST_INIT: begin
        // clear every class head, pool class points at offset zero
        rec_req.wr_en    = 1'b1;
        rec_req.wr_addr  = '0;
        rec_req.wr_data  = '{len: POOL_LEN, free: 1'b1, pprev: NO_LINK,
                             pnext: NO_LINK, fprev: NO_LINK, fnext: NO_LINK};
        head_req.wr_en   = 1'b1;
        head_req.wr_addr = init_r;
        head_req.wr_data = (init_r == POOL_CLASS) ? '0 : NO_LINK;
        init_nxt         = init_r + CLS_W'(1);
      end
      ST_IDLE: begin
        total_nxt  = 17'(in_request_bytes) + HDR_LEN;
        if (17'(in_request_bytes) + HDR_LEN < MIN_LEN) total_nxt = MIN_LEN;
        b_nxt      = in_block_address - HDR_OFS;
        addr_nxt   = '0;
        status_nxt = (in_operation && in_block_address == '0) ? STAT_IGNORED : STAT_DONE;
      end
      ST_A_MAP:  cls_nxt = total_req;
      ST_A_FIND: begin
        if (found) begin
          head_req.rd_en   = 1'b1;
          head_req.rd_addr = found_cls;
          head_vld_nxt     = 1'b1;
        end else begin
          status_nxt = STAT_NO_SPACE;
        end
      end
      ST_A_HEAD: begin
        if (head_q[16]) begin
          status_nxt = STAT_NO_SPACE;
        end else begin
          b_nxt   = head_q[15:0];
          x_nxt   = head_q[15:0];
          ret_nxt = ST_A_CHK;
        end
      end
      ST_RM_RD: begin
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = x_r;
      end
      ST_RM_GET: begin
        p_nxt   = rec_q.fprev;
        n_nxt   = rec_q.fnext;
        cls_nxt = q_cls;
        if (!rec_q.fprev[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = rec_q.fprev[15:0];
        end else begin
          head_req.wr_en   = 1'b1;
          head_req.wr_addr = q_cls;
          head_req.wr_data = rec_q.fnext;
        end
        if (rm_empty) sl_bm_nxt[q_cls[8:4]][q_cls[3:0]] = 1'b0;
      end
      ST_RM_PW: begin
        w.fnext         = n_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = p_r[15:0];
        rec_req.wr_data = w;
      end
      ST_RM_N: begin
        if (!n_r[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = n_r[15:0];
        end
      end
      ST_RM_NW: begin
        w.fprev         = p_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = n_r[15:0];
        rec_req.wr_data = w;
      end
      ST_A_CHK, ST_SP_B, ST_A_CLR, ST_F_MK, ST_M_RD, ST_M_PV, ST_M_P1: begin
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = b_r;
      end
      ST_A_CHK2: begin
        x_nxt   = b_r + total_r[15:0];
        len_nxt = rec_q.len - total_r;
        lk_nxt  = rec_q.pnext;
      end
      ST_SP_NB_RD, ST_IN_RD: begin
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = x_r;
      end
      ST_SP_NB_WR: begin
        w.len           = len_r;
        w.free          = 1'b1;
        w.pprev         = {1'b0, b_r};
        w.pnext         = lk_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = x_r;
        rec_req.wr_data = w;
      end
      ST_SP_NX, ST_M_N4, ST_M_P4: begin
        if (!lk_r[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = lk_r[15:0];
        end
      end
      ST_SP_NXW: begin
        w.pprev         = {1'b0, x_r};
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = lk_r[15:0];
        rec_req.wr_data = w;
      end
      ST_SP_BW: begin
        w.pnext         = {1'b0, x_r};
        w.len           = total_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = b_r;
        rec_req.wr_data = w;
        ret_nxt         = ST_A_CLR;
      end
      ST_A_CLRW: begin
        w.free          = 1'b0;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = b_r;
        rec_req.wr_data = w;
        addr_nxt        = b_r + HDR_OFS;
      end
      ST_IN_GET: begin
        rec_nxt          = rec_q;
        cls_nxt          = q_cls;
        head_req.rd_en   = 1'b1;
        head_req.rd_addr = q_cls;
        head_vld_nxt     = 1'b1;
      end
      ST_IN_HEAD: begin
        w               = rec_r;
        w.fnext         = head_q;
        w.fprev         = NO_LINK;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = x_r;
        rec_req.wr_data = w;
        n_nxt           = head_q;
      end
      ST_IN_HRD: begin
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = n_r[15:0];
      end
      ST_IN_HW: begin
        w.fprev         = {1'b0, x_r};
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = n_r[15:0];
        rec_req.wr_data = w;
      end
      ST_IN_FIN: begin
        head_req.wr_en   = 1'b1;
        head_req.wr_addr = cls_r;
        head_req.wr_data = {1'b0, x_r};
        sl_bm_nxt[cls_r[8:4]][cls_r[3:0]] = 1'b1;
      end
      ST_F_MKW: begin
        w.free          = 1'b1;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = b_r;
        rec_req.wr_data = w;
      end
      ST_M_NX: begin
        m_nxt = rec_q.pnext[15:0];
        if (!rec_q.pnext[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = rec_q.pnext[15:0];
        end
      end
      ST_M_NXF: begin
        if (rec_q.free) begin
          x_nxt   = m_r;
          ret_nxt = ST_M_N1;
        end
      end
      ST_M_N1: begin
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = m_r;
      end
      ST_M_N2: begin
        len_nxt         = rec_q.len;
        lk_nxt          = rec_q.pnext;
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = b_r;
      end
      ST_M_N3: begin
        w.len           = rec_q.len + len_r;
        w.pnext         = lk_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = b_r;
        rec_req.wr_data = w;
      end
      ST_M_N5: begin
        w.pprev         = {1'b0, b_r};
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = lk_r[15:0];
        rec_req.wr_data = w;
      end
      ST_M_PV2: begin
        m_nxt = rec_q.pprev[15:0];
        if (!rec_q.pprev[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = rec_q.pprev[15:0];
        end else begin
          x_nxt   = b_r;
          ret_nxt = ST_LF;
        end
      end
      ST_M_PVF: begin
        if (rec_q.free) begin
          x_nxt   = m_r;
          ret_nxt = ST_M_P1;
        end else begin
          x_nxt   = b_r;
          ret_nxt = ST_LF;
        end
      end
      ST_M_P2: begin
        len_nxt         = rec_q.len;
        lk_nxt          = rec_q.pnext;
        rec_req.rd_en   = 1'b1;
        rec_req.rd_addr = m_r;
      end
      ST_M_P3: begin
        w.len           = rec_q.len + len_r;
        w.pnext         = lk_r;
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = m_r;
        rec_req.wr_data = w;
        b_nxt           = m_r;
        x_nxt           = m_r;
        ret_nxt         = ST_LF;
      end
      ST_M_P5: begin
        w.pprev         = {1'b0, m_r};
        rec_req.wr_en   = 1'b1;
        rec_req.wr_addr = lk_r[15:0];
        rec_req.wr_data = w;
      end
      ST_LF: begin
        lf_nxt = '0;
        if (fl_bm != '0) begin
          head_req.rd_en   = 1'b1;
          head_req.rd_addr = {tf, ts};
          head_vld_nxt     = 1'b1;
        end
      end
      ST_LF_H: begin
        if (!head_q[16]) begin
          rec_req.rd_en   = 1'b1;
          rec_req.rd_addr = head_q[15:0];
        end
      end
      ST_LF_L: begin
        lf_nxt = (rec_q.len > HDR_LEN) ? rec_q.len - HDR_LEN : '0;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = (state_r == ST_OUT);
  assign out_status             = status_r;
  assign out_result_address     = addr_r;
  assign out_largest_free_bytes = lf_r;

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rec_req.rd_en && rec_req.wr_en) |-> (rec_req.rd_addr != rec_req.wr_addr))
    else $error("record read and write to one entry in one cycle");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rec_req.wr_en && !head_req.wr_en))
    else $error("memory write while idle");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

/* rtl/two_level_segregated_fit_allocator_top.sv */
// ----------------------------------------------------------------------------
// two_level_segregated_fit_allocator_top
// Two-level segregated-fit allocator: header records and class heads in RAM.
// ----------------------------------------------------------------------------
// throughput: one item at a time; busy drops in the cycle after the result
//   strobe, set by the sequential walk over the header record memory
// reset: synchronous active-low; an init pass then fills every class head
//   and writes the pool header while busy stays high
module two_level_segregated_fit_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_block_address,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_address,
  output logic [16:0] out_largest_free_bytes
);
  import tlsf_pkg::*;

  rec_req_t         rec_req;
  head_req_t        head_req;
  logic [REC_W-1:0] rec_rd_data;
  logic [LEN_W-1:0] head_rd_data;

  tlsf_ctrl u_ctrl (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_operation           (in_operation),
    .in_request_bytes       (in_request_bytes),
    .in_block_address       (in_block_address),
    .out_strobe             (out_strobe),
    .out_status             (out_status),
    .out_result_address     (out_result_address),
    .out_largest_free_bytes (out_largest_free_bytes),
    .rec_req                (rec_req),
    .rec_q                  (rec_t'(rec_rd_data)),
    .head_req               (head_req),
    .head_raw               (head_rd_data)
  );

  tlsf_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_rec_ram (
    .clk     (clk),
    .rd_en   (rec_req.rd_en),
    .rd_addr (rec_req.rd_addr),
    .rd_data (rec_rd_data),
    .wr_en   (rec_req.wr_en),
    .wr_addr (rec_req.wr_addr),
    .wr_data (rec_req.wr_data)
  );

  tlsf_ram #(.WIDTH(LEN_W), .DEPTH(CLS_COUNT)) u_head_ram (
    .clk     (clk),
    .rd_en   (head_req.rd_en),
    .rd_addr (head_req.rd_addr),
    .rd_data (head_rd_data),
    .wr_en   (head_req.wr_en),
    .wr_addr (head_req.wr_addr),
    .wr_data (head_req.wr_data)
  );

endmodule
